@@ src/a2ba_pkg.sv @@
package a2ba_pkg;

    // Widths of the vector components and of the result.
    localparam int IN_W     = 29;
    localparam int MAG_W    = IN_W;
    localparam int ANGLE_W  = 32;
    localparam int QUAD_W   = 2;
    localparam int GM_W     = ANGLE_W - QUAD_W;

    // Default number of fraction bits in the quotient.
    localparam int QUOT_FRAC_BITS_DEF = 24;

    // Polynomial coefficients scaled to binary angle.
    localparam int T_W  = 30;
    localparam int K4_W = 27;
    localparam logic [T_W-1:0]  ATAN_K3 = 30'd664692038;
    localparam logic [K4_W-1:0] ATAN_K4 = 27'd131210355;

    // Sideband that travels with each transaction down the pipeline.
    typedef struct packed {
        logic [QUAD_W-1:0] quad;
        logic              neg;
        logic              zero;
    } side_t;

endpackage

@@ src/a2ba_octant.sv @@
module a2ba_octant (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [a2ba_pkg::IN_W-1:0]  x_offset,
    input  logic signed [a2ba_pkg::IN_W-1:0]  y_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [a2ba_pkg::MAG_W-1:0]        num_mag,
    output logic [a2ba_pkg::MAG_W-1:0]        den_mag,
    output a2ba_pkg::side_t                   side
);
    import a2ba_pkg::*;

    logic [IN_W:0]      xs, ys, u, v, num, den;
    logic               uneg, vneg, swap, zero;
    logic [MAG_W-1:0]   nm_next, dm_next;
    side_t              side_next;
    logic               valid_reg;
    logic [MAG_W-1:0]   nm_reg, dm_reg;
    side_t              side_reg;

    // Sum and difference pick the octant pair; signs of u and v give the quadrant.
    always_comb
    begin
        xs   = {x_offset[IN_W-1], x_offset};
        ys   = {y_offset[IN_W-1], y_offset};
        u    = xs + ys;
        v    = xs - ys;
        uneg = u[IN_W];
        vneg = v[IN_W];
        swap = uneg ^ vneg;
        zero = (x_offset == '0) && (y_offset == '0);
        num  = swap ? (IN_W+1)'(0) - xs : ys;
        den  = swap ? ys : xs;
        nm_next = num[IN_W] ? MAG_W'((IN_W+1)'(0) - num) : num[MAG_W-1:0];
        dm_next = den[IN_W] ? MAG_W'((IN_W+1)'(0) - den) : den[MAG_W-1:0];
        // The zero vector divides 0 by 1, so the quotient and angle come out zero.
        if (zero)
        begin
            dm_next = MAG_W'(1);
        end
        side_next.quad = {uneg, swap};
        side_next.neg  = (num[IN_W] ^ den[IN_W]) && (nm_next != '0);
        side_next.zero = zero;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            nm_reg   <= nm_next;
            dm_reg   <= dm_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign num_mag   = nm_reg;
    assign den_mag   = dm_reg;
    assign side      = side_reg;

endmodule

@@ src/a2ba_div.sv @@
module a2ba_div #(
    parameter int FRAC_BITS = a2ba_pkg::QUOT_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [a2ba_pkg::MAG_W-1:0]    num_mag,
    input  logic [a2ba_pkg::MAG_W-1:0]    den_mag,
    input  a2ba_pkg::side_t               in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [FRAC_BITS:0]            quot,
    output a2ba_pkg::side_t               out_side
);
    import a2ba_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int NSTEP = FRAC_BITS + 1;
    localparam logic [QW-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // One restoring step per stage, one quotient bit per step, MSB first.
    logic             v_reg   [NSTEP];
    logic [MAG_W-1:0] rem_reg [NSTEP];
    logic [MAG_W-1:0] dm_reg  [NSTEP];
    logic [QW-1:0]    q_reg   [NSTEP];
    side_t            sd_reg  [NSTEP];
    logic             rdy     [NSTEP+1];

    assign rdy[NSTEP] = out_ready;

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic [MAG_W-1:0] dm_in;
        logic [QW-1:0]    q_in;
        side_t            sd_in;
        logic             v_in;
        logic             ge;
        logic [MAG_W-1:0] rem_next;
        logic [QW-1:0]    q_next;

        // The first step compares the numerator itself; later ones the doubled remainder.
        if (j == 0)
        begin : g_first
            assign trial = {1'b0, num_mag};
            assign dm_in = den_mag;
            assign q_in  = '0;
            assign sd_in = in_side;
            assign v_in  = in_valid;
        end
        else
        begin : g_next
            assign trial = {rem_reg[j-1], 1'b0};
            assign dm_in = dm_reg[j-1];
            assign q_in  = q_reg[j-1];
            assign sd_in = sd_reg[j-1];
            assign v_in  = v_reg[j-1];
        end

        // Trial subtraction; the remainder always stays below the divisor.
        always_comb
        begin
            diff     = trial - {1'b0, dm_in};
            ge       = !diff[MAG_W];
            rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            q_next   = {q_in[QW-2:0], ge};
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j] <= rem_next;
                dm_reg[j]  <= dm_in;
                q_reg[j]   <= q_next;
                sd_reg[j]  <= sd_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTEP-1];
    assign quot      = q_reg[NSTEP-1];
    assign out_side  = sd_reg[NSTEP-1];

`ifndef ASSERT_OFF
    // The smaller component over the larger never exceeds one.
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTEP-1] |-> q_reg[NSTEP-1] <= Q_ONE)
        else $error("quotient exceeds one");
`endif

endmodule

@@ src/a2ba_poly.sv @@
module a2ba_poly #(
    parameter int FRAC_BITS = a2ba_pkg::QUOT_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [FRAC_BITS:0]              quot,
    input  a2ba_pkg::side_t                 in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [a2ba_pkg::ANGLE_W-1:0]    angle,
    output logic                            zero_vector
);
    import a2ba_pkg::*;

    localparam int QW   = FRAC_BITS + 1;
    localparam int SQ_W = 2 * QW;
    localparam int KP_W = K4_W + QW;
    localparam int GP_W = T_W + QW;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [QW-1:0]      q1_reg, q2_reg, q3_reg;
    side_t              sd1_reg, sd2_reg, sd3_reg, sd4_reg;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [QW-1:0]      qsq;
    logic [KP_W-1:0]    kp_reg, kp_next;
    logic [K4_W-1:0]    kp_shr;
    logic [T_W-1:0]     t_reg, t_next;
    logic [GP_W-1:0]    gp_reg, gp_next;
    logic [GM_W-1:0]    gm;
    logic [ANGLE_W-1:0] g_abs, g_sgn;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic               zero_reg;

    // Datapath: square, scale by K4, subtract from K3, multiply by q, apply the sign, add quadrant.
    always_comb
    begin
        sq_next    = SQ_W'(quot) * SQ_W'(quot);
        qsq        = sq_reg[FRAC_BITS +: QW];
        kp_next    = KP_W'(ATAN_K4) * KP_W'(qsq);
        kp_shr     = kp_reg[FRAC_BITS +: K4_W];
        t_next     = ATAN_K3 - T_W'(kp_shr);
        gp_next    = GP_W'(q3_reg) * GP_W'(t_reg);
        gm         = gp_reg[FRAC_BITS +: GM_W];
        g_abs      = ANGLE_W'(gm);
        g_sgn      = sd4_reg.neg ? ANGLE_W'(0) - g_abs : g_abs;
        angle_next = {sd4_reg.quad, {GM_W{1'b0}}} + g_sgn;
    end

    // Each stage advances when it is empty or the next one takes its transaction.
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            q1_reg  <= quot;
            sd1_reg <= in_side;
            sq_reg  <= sq_next;
        end
        if (rdy2)
        begin
            q2_reg  <= q1_reg;
            sd2_reg <= sd1_reg;
            kp_reg  <= kp_next;
        end
        if (rdy3)
        begin
            q3_reg  <= q2_reg;
            sd3_reg <= sd2_reg;
            t_reg   <= t_next;
        end
        if (rdy4)
        begin
            sd4_reg <= sd3_reg;
            gp_reg  <= gp_next;
        end
        if (rdy5)
        begin
            angle_reg <= angle_next;
            zero_reg  <= sd4_reg.zero;
        end
    end

    assign out_valid   = v5_reg;
    assign angle       = angle_reg;
    assign zero_vector = zero_reg;

`ifndef ASSERT_OFF
    // The correction term never exceeds K4, so t stays between K3 - K4 and K3.
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (t_reg <= ATAN_K3) && (t_reg >= ATAN_K3 - T_W'(ATAN_K4)))
        else $error("polynomial term out of range");
`endif

endmodule

@@ src/atan2_binary_angle_approx_top.sv @@
// Direction of a signed vector as a 32-bit binary angle.
//
// Input channel: in_valid/in_ready with x_offset and y_offset, 29-bit signed.
// Output channel: out_valid/out_ready with angle (full circle = 2^32, zero
// along positive x, counter-clockwise) and zero_vector, set for (0, 0) with
// angle forced to zero. Every input transaction yields one output transaction.
//
// The pipeline has one octant stage, one divider stage per quotient bit
// (QUOTIENT_FRAC_BITS + 1 of them) and five polynomial stages. Throughput is
// one transaction per cycle while the receiver takes results; the divider
// pipeline sets the depth.
//
// Reset clears all stage valid bits, so the pipeline comes up empty with
// in_ready high. When the receiver stalls, stages fill up from the output
// side and in_ready drops only once the stage behind the input is occupied;
// empty stages keep absorbing new transactions meanwhile.
module atan2_binary_angle_approx_top #(
    parameter int QUOTIENT_FRAC_BITS = a2ba_pkg::QUOT_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [a2ba_pkg::IN_W-1:0]  x_offset,
    input  logic signed [a2ba_pkg::IN_W-1:0]  y_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [a2ba_pkg::ANGLE_W-1:0]      angle,
    output logic                              zero_vector
);
    import a2ba_pkg::*;

    logic               oct_valid, oct_ready;
    logic [MAG_W-1:0]   oct_nm, oct_dm;
    side_t              oct_side;
    logic               div_valid, div_ready;
    logic [QUOTIENT_FRAC_BITS:0] div_quot;
    side_t              div_side;

    // Octant reduction and magnitudes.
    a2ba_octant u_octant (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_offset  (x_offset),
        .y_offset  (y_offset),
        .out_valid (oct_valid),
        .out_ready (oct_ready),
        .num_mag   (oct_nm),
        .den_mag   (oct_dm),
        .side      (oct_side)
    );

    // Pipelined restoring divider.
    a2ba_div #(
        .FRAC_BITS (QUOTIENT_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (oct_valid),
        .in_ready  (oct_ready),
        .num_mag   (oct_nm),
        .den_mag   (oct_dm),
        .in_side   (oct_side),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    // Arctangent polynomial and quadrant offset.
    a2ba_poly #(
        .FRAC_BITS (QUOTIENT_FRAC_BITS)
    ) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (div_valid),
        .in_ready    (div_ready),
        .quot        (div_quot),
        .in_side     (div_side),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle       (angle),
        .zero_vector (zero_vector)
    );

`ifndef ASSERT_OFF
    // A zero vector always reports angle zero.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_vector |-> angle == '0)
        else $error("zero vector with nonzero angle");

    // A receiver that takes results never backs up the input.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // The octant stage flags a zero vector only for two zero components.
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (x_offset != '0) |=> !(oct_valid && oct_side.zero))
        else $error("zero flag on nonzero vector");
`endif

endmodule
